// ===== rtl/bfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Bit field packer package
// Shared types, constants and the float narrowing function.
// ----------------------------------------------------------------------------
package bfp_pkg;

  localparam int unsigned MaxFieldWidthDef = 64;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    KIND_UNSIGNED = 2'd0,
    KIND_SIGNED   = 2'd1,
    KIND_FLOAT    = 2'd2,
    KIND_PAD      = 2'd3
  } kind_e;

  // Classified field handed from the front end to the back end.
  typedef struct packed {
    logic [63:0] bits;
    logic [6:0]  width;
    logic        last;
    logic        flag;
  } field_t;

  // Narrows a double bit pattern to a 16, 32 or 64 bit float.
  // Returns {flag, bits}.
  function automatic logic [64:0] narrow_float(input logic [63:0] d, input logic [6:0] w);
    logic        sign;
    logic [10:0] dexp;
    logic [51:0] dman;
    logic [12:0] t;
    logic [12:0] emax;
    logic [63:0] res;
    logic        flag;
    res  = '0;
    flag = 1'b0;
    sign = d[63];
    dexp = d[62:52];
    dman = d[51:0];
    if (w == 7'd16 || w == 7'd32 || w == 7'd64) begin
      emax = (w == 7'd16) ? 13'd31 : (w == 7'd32) ? 13'd255 : 13'd2047;
      // Biased exponent in the target format, two's complement.
      t = {2'b00, dexp} - 13'd1023 + (emax >> 1);
      if (dexp == 11'h7ff || (!t[12] && t != 13'd0 && t >= emax)) begin
        flag = 1'b1;
        t = emax;
        dman = '0;
      end else if (dexp == 11'd0 || t[12] || t == 13'd0) begin
        t = '0;
        dman = '0;
      end
      unique case (w)
        7'd16:   res = {48'd0, sign, t[4:0], dman[51:42]};
        7'd32:   res = {32'd0, sign, t[7:0], dman[51:29]};
        default: res = {sign, t[10:0], dman};
      endcase
    end else begin
      flag = 1'b1;
    end
    return {flag, res};
  endfunction

endpackage

// ===== rtl/bfp_front.sv =====
// ----------------------------------------------------------------------------
// Bit field packer front end
// Accepts a field word, clamps width, masks, narrows or zeroes (pad) the value.
// ----------------------------------------------------------------------------
module bfp_front #(
  parameter int unsigned MaxFieldWidth = bfp_pkg::MaxFieldWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [1:0]             req_type_i,
  input  logic [6:0]             field_width_i,
  input  logic [63:0]            field_value_i,
  input  logic                   last_field_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output bfp_pkg::field_t        field_o
);

  bfp_pkg::field_t field_q, field_d;
  logic            valid_q;
  logic [6:0]      w;
  logic [63:0]     mask;
  logic [64:0]     nf;

  always_comb begin
    w = (field_width_i > 7'(MaxFieldWidth)) ? 7'(MaxFieldWidth) : field_width_i;
    mask = (w >= 7'd64) ? '1 : ((64'd1 << w) - 64'd1);
    nf = bfp_pkg::narrow_float(field_value_i, w);
    field_d.width = w;
    field_d.last  = last_field_i;
    field_d.flag  = 1'b0;
    case (bfp_pkg::kind_e'(req_type_i))
      bfp_pkg::KIND_FLOAT: begin
        field_d.bits = nf[63:0] & mask;
        field_d.flag = nf[64];
      end
      bfp_pkg::KIND_PAD: field_d.bits = '0;
      default:           field_d.bits = field_value_i & mask;
    endcase
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign field_o = field_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      field_q <= field_d;
    end
  end

endmodule

// ===== rtl/bfp_queue.sv =====
// ----------------------------------------------------------------------------
// Bit field packer queue
// Two-entry queue of classified fields between front and back end.
// ----------------------------------------------------------------------------
module bfp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  bfp_pkg::field_t field_i,
  output logic            valid_o,
  input  logic            ready_i,
  output bfp_pkg::field_t field_o
);

  bfp_pkg::field_t mem_q [bfp_pkg::QueueDepth];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;

  assign ready_o = cnt_q != 2'(bfp_pkg::QueueDepth);
  assign valid_o = cnt_q != 2'd0;
  assign field_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (valid_i && ready_o) wr_q <= !wr_q;
      if (valid_o && ready_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(valid_i && ready_o) - 2'(valid_o && ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) mem_q[wr_q] <= field_i;
  end

endmodule

// ===== rtl/bfp_back.sv =====
// ----------------------------------------------------------------------------
// Bit field packer back end
// Shifts field bits into the pending byte, emits one byte per cycle while the output accepts.
// ----------------------------------------------------------------------------
module bfp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  bfp_pkg::field_t field_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            last_byte_o,
  output logic            range_flag_o
);

  logic [63:0] bits_q;
  logic [6:0]  rem_q;
  logic        last_q, flag_q, busy_q;
  logic [6:0]  pend_q;
  logic [2:0]  cnt_q;
  logic        ovalid_q, olast_q, oflag_q;
  logic [7:0]  obyte_q;

  logic        out_free, emit_full, emit_flush, done;
  logic [3:0]  take;
  logic [7:0]  byte_w;
  logic [7:0]  cmask;
  logic [7:0]  low8;
  logic [6:0]  rem_after;

  assign out_free = !ovalid_q || out_ready_i;
  assign ready_o  = !busy_q;

  always_comb begin
    take      = 4'd8 - {1'b0, cnt_q};
    cmask     = 8'hff << cnt_q;
    low8      = bits_q[7:0] << cnt_q;
    byte_w    = ({1'b0, pend_q} & ~cmask) | (low8 & cmask);
    emit_full = busy_q && ({4'd0, cnt_q} + rem_q >= 7'd8);
    emit_flush = busy_q && !emit_full && last_q && ({4'd0, cnt_q} + rem_q != 7'd0);
    rem_after = emit_full ? rem_q - {3'd0, take} : 7'd0;
    // Field finished when no full byte remains to emit.
    done = busy_q && (emit_full ? ({4'd0, cnt_q} + rem_q == 7'd8 && !last_q) ||
                                   ({4'd0, cnt_q} + rem_q == 7'd8 && last_q)
                                : 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      pend_q   <= '0;
      ovalid_q <= 1'b0;
      bits_q   <= '0;
      rem_q    <= '0;
      last_q   <= 1'b0;
      flag_q   <= 1'b0;
      obyte_q  <= '0;
      olast_q  <= 1'b0;
      oflag_q  <= 1'b0;
    end else begin
      if (out_free && (emit_full || emit_flush)) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      if (!busy_q) begin
        if (valid_i) begin
          busy_q <= 1'b1;
          bits_q <= field_i.bits;
          rem_q  <= field_i.width;
          last_q <= field_i.last;
          flag_q <= field_i.flag;
        end
      end else if (out_free) begin
        if (emit_full || emit_flush) begin
          obyte_q  <= byte_w;
          oflag_q  <= flag_q;
          olast_q  <= last_q && (emit_flush ||
                      ({4'd0, cnt_q} + rem_q == 7'd8));
        end
        if (emit_full) begin
          bits_q <= bits_q >> take;
          rem_q  <= rem_after;
          cnt_q  <= '0;
          pend_q <= '0;
          if ({4'd0, cnt_q} + rem_q == 7'd8) busy_q <= 1'b0;
        end else begin
          busy_q <= 1'b0;
          if (last_q) begin
            cnt_q  <= '0;
            pend_q <= '0;
          end else begin
            cnt_q  <= cnt_q + rem_q[2:0];
            pend_q <= byte_w[6:0];
          end
        end
      end
    end
  end

  assign out_valid_o  = ovalid_q;
  assign out_byte_o   = obyte_q;
  assign last_byte_o  = olast_q;
  assign range_flag_o = oflag_q;

  // Pending plus remaining bits stay below a byte whenever no full byte is emitted.
  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !emit_full |-> ({4'd0, cnt_q} + rem_q < 7'd8))
    else $error("remainder does not fit in pending byte");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !out_ready_i |=> ovalid_q && $stable(obyte_q))
    else $error("output byte lost under stall");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> busy_q)
    else $error("finish without field");

endmodule

// ===== rtl/bit_field_packer.sv =====
// ----------------------------------------------------------------------------
// Bit field packer
// Packs kind-tagged fields LSB first into a byte stream.
// ----------------------------------------------------------------------------
// A field passes the front-end register, the queue, the back end's field
// register and the output register. The back end emits one byte per cycle
// while the output accepts, with a load step per field, and takes no field
// while busy; the front end and a two-entry queue keep accepting meanwhile.
// Reset clears the pending byte, the queue and all valid flags.
module bit_field_packer #(
  parameter int unsigned MaxFieldWidth = bfp_pkg::MaxFieldWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [6:0]  field_width_i,
  input  logic [63:0] field_value_i,
  input  logic        last_field_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_byte_o,
  output logic        range_flag_o
);

  // Front end: classification and value preparation into one register.
  bfp_pkg::field_t f_field, q_field;
  logic            f_valid, f_ready, q_valid, q_ready;

  bfp_front #(.MaxFieldWidth(MaxFieldWidth)) u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o,
    .req_type_i, .field_width_i, .field_value_i, .last_field_i,
    .valid_o(f_valid), .ready_i(f_ready), .field_o(f_field)
  );

  // Queue decoupling classification from byte emission.
  bfp_queue u_queue (
    .clk_i, .rst_ni,
    .valid_i(f_valid), .ready_o(f_ready), .field_i(f_field),
    .valid_o(q_valid), .ready_i(q_ready), .field_o(q_field)
  );

  // Back end: the byte assembler.
  bfp_back u_back (
    .clk_i, .rst_ni,
    .valid_i(q_valid), .ready_o(q_ready), .field_i(q_field),
    .out_valid_o(valid_o), .out_ready_i(ready_i),
    .out_byte_o, .last_byte_o, .range_flag_o
  );

endmodule
